### sv/ftsc_pkg.sv
// ----------------------------------------------------------------------------
// ftsc_pkg
// Types and constants shared by the file type signature classifier.
// ----------------------------------------------------------------------------
package ftsc_pkg;

	localparam int HDR_LEN        = 12;
	localparam int FILL_W         = 4;
	localparam int CNT_W          = 14;
	localparam int MARKER_COUNT   = 6;
	localparam int MARKER_MAX_LEN = 55;

	typedef enum logic [4:0] {
		TC_JPEG  = 5'd0,
		TC_PNG   = 5'd1,
		TC_BMP   = 5'd2,
		TC_TIFF  = 5'd3,
		TC_WEBP  = 5'd4,
		TC_WAV   = 5'd5,
		TC_PDF   = 5'd6,
		TC_HEIC  = 5'd7,
		TC_AVIF  = 5'd8,
		TC_MP4   = 5'd9,
		TC_GIF   = 5'd10,
		TC_ICON  = 5'd11,
		TC_GZIP  = 5'd12,
		TC_7Z    = 5'd13,
		TC_RAR   = 5'd14,
		TC_DOCX  = 5'd15,
		TC_XLSX  = 5'd16,
		TC_PPTX  = 5'd17,
		TC_ODT   = 5'd18,
		TC_ODS   = 5'd19,
		TC_ODP   = 5'd20,
		TC_ZIP   = 5'd21,
		TC_TEXT  = 5'd22,
		TC_OCTET = 5'd23
	} type_code_t;

	typedef struct packed {
		logic [0:HDR_LEN-1][7:0]  hdr;
		logic [FILL_W-1:0]        fill;
		logic [MARKER_COUNT-1:0]  seen;
		logic                     nul;
		logic [CNT_W-1:0]         odd;
		logic [CNT_W-1:0]         len;
	} file_summary_t;

	localparam int MARKER_LEN [MARKER_COUNT] = '{17, 15, 20, 47, 54, 55};

	localparam logic [8*MARKER_MAX_LEN-1:0] MARKER_TEXT [MARKER_COUNT] = '{
		"word/document.xml",
		"xl/workbook.xml",
		"ppt/presentation.xml",
		"mimetypeapplication/vnd.oasis.opendocument.text",
		"mimetypeapplication/vnd.oasis.opendocument.spreadsheet",
		"mimetypeapplication/vnd.oasis.opendocument.presentation"
	};

endpackage

### sv/file_type_signature_classifier_top.sv
// ----------------------------------------------------------------------------
// file_type_signature_classifier_top
// Streams a file one byte per item and reports its type on the final byte.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): data_byte with last_byte marking the
// final byte of a file. Files hold at least one byte and follow each other
// with no gap.
// Output channel (out_valid / out_stall): one type_code per file.
// An accepted byte lands in the input register; as it advances, a non-final
// byte updates the header store, the marker window and the text counters,
// while for a final byte the type code is written to the result register,
// which drives out_valid, and the file state is cleared.
// Throughput is one byte per cycle, set by the combinational window comparators
// and header compare chain; files end-to-end run at full rate unless the output stalls.
// A stall on the output holds the result; non-final bytes keep flowing and
// only a second final byte waits until the result is taken.
// Reset clears all file state, both valid flags and the marker window; after
// each final byte the state returns to its reset value for the next file.
// ----------------------------------------------------------------------------
module file_type_signature_classifier_top import ftsc_pkg::*; #(
	parameter int SAMPLE_LIMIT = 8192,
	parameter int WINDOW_BYTES = 55
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] type_code
);

	localparam logic [CNT_W-1:0] SAMPLE_MAX = CNT_W'(SAMPLE_LIMIT);

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    last_s1;
	logic                    adv;
	logic                    in_acc;

	logic [0:HDR_LEN-1][7:0] hdr_q;
	logic [FILL_W-1:0]       fill_q;
	logic [7:0]              win_q [0:WINDOW_BYTES-2];
	logic [MARKER_COUNT-1:0] seen_q;
	logic [CNT_W-1:0]        len_q;
	logic [CNT_W-1:0]        odd_q;
	logic                    nul_q;

	logic [7:0]              view [0:WINDOW_BYTES-1];
	logic [MARKER_COUNT-1:0] hit;
	logic                    odd_byte;
	file_summary_t           nxt;
	type_code_t              code;
	logic                    out_valid_q;
	type_code_t              code_q;

	// input register and flow control
	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// marker comparators over the window plus the incoming byte
	always_comb begin
		for (int k = 0; k < WINDOW_BYTES - 1; k++) begin
			view[k] = win_q[k];
		end
		view[WINDOW_BYTES-1] = byte_s1;
	end

	for (genvar m = 0; m < MARKER_COUNT; m++) begin : g_marker
		logic [MARKER_MAX_LEN-1:0] byte_ok;
		for (genvar i = 0; i < MARKER_MAX_LEN; i++) begin : g_char
			if (i < MARKER_LEN[m]) begin : g_cmp
				assign byte_ok[i] = view[WINDOW_BYTES-MARKER_LEN[m]+i] ==
					MARKER_TEXT[m][8*(MARKER_LEN[m]-1-i) +: 8];
			end else begin : g_pad
				assign byte_ok[i] = 1'b1;
			end
		end
		assign hit[m] = &byte_ok;
	end

	assign odd_byte = !(byte_s1 == 8'h09 || byte_s1 == 8'h0A || byte_s1 == 8'h0D ||
		(byte_s1 >= 8'h20 && byte_s1 < 8'h7F) || byte_s1 >= 8'h80);

	// state including the current byte
	always_comb begin
		nxt.hdr  = hdr_q;
		nxt.fill = fill_q;
		if (fill_q < FILL_W'(HDR_LEN)) begin
			nxt.hdr[fill_q] = byte_s1;
			nxt.fill        = fill_q + FILL_W'(1);
		end
		nxt.seen = seen_q | hit;
		nxt.len  = len_q;
		nxt.odd  = odd_q;
		nxt.nul  = nul_q;
		if (len_q < SAMPLE_MAX) begin
			nxt.len = len_q + CNT_W'(1);
			nxt.odd = odd_q + CNT_W'(odd_byte);
			nxt.nul = nul_q | (byte_s1 == 8'h00);
		end
	end

	ftsc_classify u_classify (
		.summary (nxt),
		.code    (code)
	);

	// advance file state; drop it after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q  <= '0;
			fill_q <= '0;
			seen_q <= '0;
			len_q  <= '0;
			odd_q  <= '0;
			nul_q  <= 1'b0;
			for (int k = 0; k < WINDOW_BYTES - 1; k++) begin
				win_q[k] <= '0;
			end
		end else if (adv) begin
			if (last_s1) begin
				hdr_q  <= '0;
				fill_q <= '0;
				seen_q <= '0;
				len_q  <= '0;
				odd_q  <= '0;
				nul_q  <= 1'b0;
				for (int k = 0; k < WINDOW_BYTES - 1; k++) begin
					win_q[k] <= '0;
				end
			end else begin
				hdr_q  <= nxt.hdr;
				fill_q <= nxt.fill;
				seen_q <= nxt.seen;
				len_q  <= nxt.len;
				odd_q  <= nxt.odd;
				nul_q  <= nxt.nul;
				for (int k = 0; k < WINDOW_BYTES - 2; k++) begin
					win_q[k] <= win_q[k+1];
				end
				win_q[WINDOW_BYTES-2] <= byte_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			code_q <= code;
		end
	end

	assign out_valid = out_valid_q;
	assign type_code = 5'(code_q);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(HDR_LEN))
		else $error("header fill beyond header length");

	a_odd_within_sample: assert property (@(posedge clk) disable iff (!arst_n)
		odd_q <= len_q && len_q <= SAMPLE_MAX)
		else $error("text counters inconsistent");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> fill_q == '0 && seen_q == '0 && len_q == '0 && !nul_q)
		else $error("file state not cleared after final item");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && last_s1))
		else $error("result without a final item");

	a_no_result_loss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !(adv && last_s1))
		else $error("pending result overwritten");

endmodule

### sv/ftsc_classify.sv
// ----------------------------------------------------------------------------
// ftsc_classify
// Priority chain of header signatures, ZIP content markers and text ratio.
// ----------------------------------------------------------------------------
module ftsc_classify import ftsc_pkg::*; (
	input  file_summary_t summary,
	output type_code_t    code
);

	logic [0:HDR_LEN-1][7:0] h;
	logic [FILL_W-1:0]       fill;
	logic [31:0]             head4;
	logic [31:0]             tag4;
	logic [31:0]             brand;
	logic [20:0]             odd_x100;
	logic                    is_text;

	assign h     = summary.hdr;
	assign fill  = summary.fill;
	assign head4 = {h[0], h[1], h[2], h[3]};
	assign tag4  = {h[4], h[5], h[6], h[7]};
	assign brand = {h[8], h[9], h[10], h[11]};

	assign odd_x100 = {7'd0, summary.odd} * 21'd100;
	assign is_text  = !summary.nul && (odd_x100 < {7'd0, summary.len});

	always_comb begin
		code = TC_OCTET;
		if (fill >= 4'd3 && h[0] == 8'hFF && h[1] == 8'hD8 && h[2] == 8'hFF) begin
			code = TC_JPEG;
		end else if (fill >= 4'd8 && head4 == 32'h89504E47 &&
				{h[4], h[5], h[6], h[7]} == 32'h0D0A1A0A) begin
			code = TC_PNG;
		end else if (fill >= 4'd2 && h[0] == 8'h42 && h[1] == 8'h4D) begin
			code = TC_BMP;
		end else if (fill >= 4'd4 && (head4 == 32'h49492A00 || head4 == 32'h4D4D002A)) begin
			code = TC_TIFF;
		end else if (fill == 4'd12 && head4 == "RIFF" && brand == "WEBP") begin
			code = TC_WEBP;
		end else if (fill == 4'd12 && head4 == "RIFF" && brand == "WAVE") begin
			code = TC_WAV;
		end else if (fill >= 4'd5 && head4 == "%PDF" && h[4] == 8'h2D) begin
			code = TC_PDF;
		end else if (fill == 4'd12 && tag4 == "ftyp") begin
			if (brand == "heic" || brand == "heix" || brand == "heim" ||
					brand == "heis" || brand == "hevc" || brand == "hevx" ||
					brand == "hevm" || brand == "hevs" || brand == "mif1" ||
					brand == "msf1") begin
				code = TC_HEIC;
			end else if (brand == "avif" || brand == "avis") begin
				code = TC_AVIF;
			end else begin
				code = TC_MP4;
			end
		end else if (fill >= 4'd4 && head4 == 32'h47494638) begin
			code = TC_GIF;
		end else if (fill >= 4'd4 && head4 == 32'h00000100) begin
			code = TC_ICON;
		end else if (fill >= 4'd2 && h[0] == 8'h1F && h[1] == 8'h8B) begin
			code = TC_GZIP;
		end else if (fill >= 4'd6 && head4 == 32'h377ABCAF &&
				h[4] == 8'h27 && h[5] == 8'h1C) begin
			code = TC_7Z;
		end else if (fill >= 4'd6 && head4 == 32'h52617221 &&
				h[4] == 8'h1A && h[5] == 8'h07) begin
			code = TC_RAR;
		end else if (fill >= 4'd4 && head4 == 32'h504B0304) begin
			if (summary.seen[0]) begin
				code = TC_DOCX;
			end else if (summary.seen[1]) begin
				code = TC_XLSX;
			end else if (summary.seen[2]) begin
				code = TC_PPTX;
			end else if (summary.seen[3]) begin
				code = TC_ODT;
			end else if (summary.seen[4]) begin
				code = TC_ODS;
			end else if (summary.seen[5]) begin
				code = TC_ODP;
			end else begin
				code = TC_ZIP;
			end
		end else if (is_text) begin
			code = TC_TEXT;
		end
	end

endmodule

### verif/tb_file_type_signature_classifier_top.sv
// ----------------------------------------------------------------------------
// tb_file_type_signature_classifier_top
// Streams whole files into the classifier byte by byte and checks the type
// code given for each one. A tracker class keeps its own header store,
// marker window and text counters, works out the expected code when the
// final byte of a file is taken, and compares it with the code that comes
// out. Directed files cover every signature, short headers, RIFF tags that
// fall through, ISOBMFF brands, each ZIP marker and the text ratio limit.
// Random files follow, mostly built round real signatures, with noise,
// corrupted and truncated headers mixed in. Both sides idle in random
// bursts, and one long output hold-off backs the block up onto its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_file_type_signature_classifier_top import ftsc_pkg::*; ();

	localparam int SAMPLE_LIM  = 8192;
	localparam int WIN_BYTES   = 55;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;
	localparam int RAND_BYTES  = 60;
	localparam int RAND_FILES  = 5;

	class file_type_tracker #(int SAMPLE_LIMIT = 8192, int WINDOW_BYTES = 55);
		logic [7:0] hdr [HDR_LEN];
		int         fill;
		logic [7:0] win [WINDOW_BYTES];
		logic [5:0] seen;
		int         sample_len;
		int         odd_cnt;
		bit         nul;
		type_code_t expected_types [$];
		int         errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			foreach (hdr[i]) hdr[i] = 8'h00;
			foreach (win[i]) win[i] = 8'h00;
			fill       = 0;
			seen       = '0;
			sample_len = 0;
			odd_cnt    = 0;
			nul        = 1'b0;
		endfunction

		function string marker_name(int i);
			case (i)
				0: return "word/document.xml";
				1: return "xl/workbook.xml";
				2: return "ppt/presentation.xml";
				3: return "mimetypeapplication/vnd.oasis.opendocument.text";
				4: return "mimetypeapplication/vnd.oasis.opendocument.spreadsheet";
				default: return "mimetypeapplication/vnd.oasis.opendocument.presentation";
			endcase
		endfunction

		function bit hdr_has(int off, int len, logic [63:0] pat);
			int k;
			if (fill < off + len || off + len > HDR_LEN) return 1'b0;
			for (k = 0; k < len; k++)
				if (hdr[off+k] != pat[8*(len-1-k) +: 8]) return 1'b0;
			return 1'b1;
		endfunction

		function type_code_t predict_type();
			logic [31:0] brand;
			int          i;
			brand = {hdr[8], hdr[9], hdr[10], hdr[11]};
			if (hdr_has(0, 3, 64'hFFD8FF)) return TC_JPEG;
			if (hdr_has(0, 8, 64'h89504E470D0A1A0A)) return TC_PNG;
			if (hdr_has(0, 2, 64'h424D)) return TC_BMP;
			if (hdr_has(0, 4, 64'h49492A00) || hdr_has(0, 4, 64'h4D4D002A)) return TC_TIFF;
			if (fill >= HDR_LEN && hdr_has(0, 4, "RIFF")) begin
				if (hdr_has(8, 4, "WEBP")) return TC_WEBP;
				if (hdr_has(8, 4, "WAVE")) return TC_WAV;
			end
			if (hdr_has(0, 5, "%PDF-")) return TC_PDF;
			if (fill >= HDR_LEN && hdr_has(4, 4, "ftyp")) begin
				case (brand)
					"heic", "heix", "heim", "heis", "hevc", "hevx", "hevm", "hevs",
					"mif1", "msf1": return TC_HEIC;
					"avif", "avis": return TC_AVIF;
					default: return TC_MP4;
				endcase
			end
			if (hdr_has(0, 4, 64'h47494638)) return TC_GIF;
			if (hdr_has(0, 4, 64'h00000100)) return TC_ICON;
			if (hdr_has(0, 2, 64'h1F8B)) return TC_GZIP;
			if (hdr_has(0, 6, 64'h377ABCAF271C)) return TC_7Z;
			if (hdr_has(0, 6, 64'h526172211A07)) return TC_RAR;
			if (hdr_has(0, 4, 64'h504B0304)) begin
				for (i = 0; i < MARKER_COUNT; i++)
					if (seen[i]) return type_code_t'(TC_DOCX + i);
				return TC_ZIP;
			end
			if (!nul && 100 * odd_cnt < sample_len) return TC_TEXT;
			return TC_OCTET;
		endfunction

		function void note_byte(logic [7:0] b, logic l);
			int    i;
			int    k;
			int    n;
			bit    hit;
			string m;
			if (fill < HDR_LEN) begin
				hdr[fill] = b;
				fill++;
			end
			for (i = 0; i < WINDOW_BYTES - 1; i++) win[i] = win[i+1];
			win[WINDOW_BYTES-1] = b;
			for (i = 0; i < MARKER_COUNT; i++) begin
				m   = marker_name(i);
				n   = m.len();
				hit = (n <= WINDOW_BYTES);
				for (k = 0; k < n && hit; k++)
					if (win[WINDOW_BYTES-n+k] != m[k]) hit = 1'b0;
				if (hit) seen[i] = 1'b1;
			end
			if (sample_len < SAMPLE_LIMIT) begin
				sample_len++;
				if (!(b == 8'h09 || b == 8'h0A || b == 8'h0D || (b >= 8'h20 && b < 8'h7F) ||
						b >= 8'h80))
					odd_cnt++;
				if (b == 8'h00) nul = 1'b1;
			end
			if (l) begin
				expected_types.push_back(predict_type());
				clear();
			end
		endfunction

		task report_mismatch(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_result(logic [4:0] code);
			type_code_t want;
			if (expected_types.size() == 0) begin
				report_mismatch($sformatf("type_code %0d with no file pending", code));
			end else begin
				want = expected_types.pop_front();
				if (code !== want)
					report_mismatch($sformatf("type_code %0d, expected %0d (%s)",
						code, want, want.name()));
			end
		endtask

		task drain_check();
			if (expected_types.size() != 0)
				report_mismatch($sformatf("%0d files never classified", expected_types.size()));
		endtask

		function int pending();
			return expected_types.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_stall = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [4:0] type_code;

	file_type_tracker #(SAMPLE_LIM, WIN_BYTES) sb;
	logic [7:0] file_buf [$];
	bit         idle_on     = 1'b1;
	bit         hold_req    = 1'b0;
	bit         hold_active = 1'b0;
	int         bytes_sent  = 0;
	int         files_sent  = 0;
	int         cycle_count = 0;
	int         brand_name_pick [5] = '{0, 8, 10, 11, 12};

	file_type_signature_classifier_top #(
		.SAMPLE_LIMIT(SAMPLE_LIM),
		.WINDOW_BYTES(WIN_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.type_code(type_code)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(type_code);
	end

	initial begin
		wait (arst_n);
		forever begin
			if (hold_req) begin
				hold_req    = 1'b0;
				hold_active = 1'b1;
				out_stall  <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
			end else if (idle_on && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat (idle_on ? $urandom_range(1, 18) : 1) @(posedge clk);
			end
		end
	end

	function string brand_name(int i);
		case (i)
			0: return "heic";
			1: return "heix";
			2: return "heim";
			3: return "heis";
			4: return "hevc";
			5: return "hevx";
			6: return "hevm";
			7: return "hevs";
			8: return "mif1";
			9: return "msf1";
			10: return "avif";
			11: return "avis";
			12: return "isom";
			default: return "mp42";
		endcase
	endfunction

	task automatic put_hex(logic [63:0] pat, int len);
		int k;
		for (k = 0; k < len; k++) file_buf.push_back(pat[8*(len-1-k) +: 8]);
	endtask

	task automatic put_str(string s);
		int k;
		for (k = 0; k < s.len(); k++) file_buf.push_back(s[k]);
	endtask

	task automatic put_rand(int n);
		repeat (n) file_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic send_byte(logic [7:0] b, logic l);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_byte(b, l);
	endtask

	task automatic send_file();
		int k;
		for (k = 0; k < file_buf.size(); k++)
			send_byte(file_buf[k], k == file_buf.size() - 1);
		bytes_sent += file_buf.size();
		files_sent++;
		file_buf.delete();
	endtask

	task automatic make_random_file();
		int    kind;
		int    n;
		int    k;
		int    r;
		string m;
		kind = $urandom_range(0, 20);
		case (kind)
			0, 1: put_rand($urandom_range(1, 30));
			2, 3: begin
				repeat ($urandom_range(1, 40)) begin
					r = $urandom_range(0, 39);
					if (r == 0) file_buf.push_back(8'h00);
					else if (r < 3) file_buf.push_back(8'($urandom_range(1, 31)));
					else if (r < 5) file_buf.push_back(8'($urandom_range(128, 255)));
					else file_buf.push_back(8'($urandom_range(32, 126)));
				end
			end
			4, 5, 6: begin
				put_hex(64'h504B0304, 4);
				put_rand($urandom_range(0, 8));
				repeat ($urandom_range(0, 2)) begin
					m = sb.marker_name($urandom_range(0, 5));
					if ($urandom_range(0, 3) == 0) m = m.substr(0, m.len() - 2);
					put_str(m);
					put_rand($urandom_range(0, 6));
				end
			end
			7: put_hex(64'hFFD8FF, 3);
			8: put_hex(64'h89504E470D0A1A0A, 8);
			9: put_str("BM");
			10: put_hex(64'h49492A00, 4);
			11: put_hex(64'h4D4D002A, 4);
			12: begin
				put_str("RIFF");
				put_rand(4);
				r = $urandom_range(0, 3);
				if (r == 0) put_str("WEBP");
				else if (r == 1) put_str("WAVE");
				else if (r == 2) put_str("AVI ");
				else put_rand(4);
			end
			13: put_str("%PDF-");
			14: begin
				put_rand(4);
				put_str("ftyp");
				if ($urandom_range(0, 4) == 0) put_rand(4);
				else put_str(brand_name($urandom_range(0, 13)));
			end
			15: put_str("GIF89a");
			16: put_hex(64'h00000100, 4);
			17: put_hex(64'h1F8B, 2);
			18: put_hex(64'h377ABCAF271C, 6);
			19: put_hex(64'h526172211A07, 6);
			default: put_hex(64'h504B0304, 4);
		endcase
		if (kind >= 7) put_rand($urandom_range(0, 16));
		if (kind >= 4 && $urandom_range(0, 5) == 0) begin
			k = $urandom_range(0, file_buf.size() < 12 ? file_buf.size() - 1 : 11);
			file_buf[k] = file_buf[k] ^ 8'($urandom_range(1, 255));
		end
		if ($urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, file_buf.size());
			while (file_buf.size() > n) void'(file_buf.pop_back());
		end
	endtask

	initial begin
		int i;
		int start_bytes;
		int start_files;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_hex(64'h00, 1);
		send_file();
		put_hex(64'hFFD8, 2);
		send_file();
		put_hex(64'hFFD8FF, 3);
		send_file();
		put_hex(64'h89504E470D0A1A0A, 8);
		put_rand(4);
		send_file();
		put_hex(64'h89504E470D0A1A, 7);
		send_file();
		put_str("BM");
		send_file();
		put_hex(64'h49492A00, 4);
		send_file();
		put_hex(64'h4D4D002A, 4);
		put_rand(3);
		send_file();
		put_str("RIFF");
		put_rand(4);
		put_str("WEBP");
		send_file();
		put_str("RIFF");
		put_rand(4);
		put_str("WAVE");
		put_rand(4);
		send_file();
		put_str("RIFF");
		put_rand(4);
		put_str("AVI ");
		send_file();
		put_str("RIFF");
		put_rand(4);
		put_str("WEB");
		send_file();
		put_str("%PDF-1.7");
		send_file();
		foreach (brand_name_pick[j]) begin
			put_rand(4);
			put_str("ftyp");
			put_str(brand_name(brand_name_pick[j]));
			send_file();
		end
		put_str("GIF89a");
		send_file();
		put_hex(64'h00000100, 4);
		put_hex(64'hFF, 1);
		send_file();
		put_hex(64'h1F8B, 2);
		send_file();
		put_hex(64'h377ABCAF271C, 6);
		send_file();
		put_hex(64'h526172211A07, 6);
		send_file();
		put_hex(64'h504B0304, 4);
		put_rand(6);
		send_file();
		for (i = 0; i < MARKER_COUNT; i++) begin
			put_hex(64'h504B0304, 4);
			put_str(sb.marker_name(i));
			send_file();
		end

		// one control byte in 100 bytes: just short of text
		repeat (99) file_buf.push_back(8'h61);
		file_buf.push_back(8'h01);
		send_file();

		// hold the output while short files keep arriving
		idle_on  = 1'b0;
		hold_req = 1'b1;
		in_valid <= 1'b0;
		while (!hold_active) @(posedge clk);
		repeat (10) begin
			put_rand($urandom_range(1, 3));
			send_file();
		end
		idle_on = 1'b1;

		start_bytes = bytes_sent;
		start_files = files_sent;
		while (bytes_sent - start_bytes < RAND_BYTES || files_sent - start_files < RAND_FILES) begin
			if (bytes_sent - start_bytes >= RAND_BYTES * 4 / 5 &&
					files_sent - start_files >= RAND_FILES * 4 / 5)
				idle_on = 1'b0;
			make_random_file();
			send_file();
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		sb.drain_check();
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### sim.f
sv/ftsc_pkg.sv
sv/ftsc_classify.sv
sv/file_type_signature_classifier_top.sv
verif/tb_file_type_signature_classifier_top.sv
